[sv/cfb_pkg.sv]
// Shared types, constants and CRC helpers for the command frame builder.
// No dependencies; every other file in sv/ refers to this package by scoped names.
package cfb_pkg;

  localparam logic [15:0] CRC_SEED    = 16'h1D0F;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  ESC_BYTE    = 8'h9E;
  localparam logic [7:0]  ESC_OFFSET  = 8'h0D;
  localparam logic [7:0]  FLAG_START  = 8'h8E;
  localparam logic [7:0]  FLAG_END    = 8'hAE;
  localparam logic [15:0] SPOOL_STOP  = 16'h0902;
  localparam logic [15:0] SPOOL_START = 16'h0900;

  localparam int HDR_LEN = 5;
  localparam int HDR_IW  = $clog2(HDR_LEN);
  localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{8'h00, 8'h12, 8'hC0, 8'hFF, 8'hEE};

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one accepted byte, classified, with the CRC after folding it in
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] crc;
  } job_t;

  typedef enum logic [3:0] {
    ST_BEGIN,
    ST_STOP,
    ST_START,
    ST_HDR,
    ST_DATA,
    ST_CRCH,
    ST_CRCL,
    ST_END,
    ST_SPOOL
  } st_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_after_hdr();
    logic [15:0] c;
    c = CRC_SEED;
    for (int i = 0; i < HDR_LEN; i++) begin
      c = crc_fold(c, HDR_BYTES[i]);
    end
    return c;
  endfunction

  localparam logic [15:0] HDR_CRC = crc_after_hdr();

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_START) || (b == ESC_BYTE) || (b == FLAG_END);
  endfunction

endpackage

[sv/cfb_front.sv]
// Front end: accepts payload bytes, runs the frame CRC and builds one job per byte.
// Depends on cfb_pkg.
module cfb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    payload_byte,
  input  logic          frame_first,
  input  logic          frame_last,
  input  logic          q_full,
  output logic          job_push,
  output cfb_pkg::job_t job
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  always_comb begin
    // a frame start reseeds, and the fixed header is already folded in
    crc_base = frame_first ? cfb_pkg::HDR_CRC : crc_r;
    crc_new  = cfb_pkg::crc_fold(crc_base, payload_byte);
    job_push = push && !q_full;
    job.data  = payload_byte;
    job.first = frame_first;
    job.last  = frame_last;
    job.crc   = crc_new;
    crc_nxt = crc_r;
    if (job_push) begin
      crc_nxt = frame_last ? cfb_pkg::CRC_SEED : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cfb_pkg::CRC_SEED;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

[sv/cfb_queue.sv]
// Short job queue between the front end and the word sequencer.
// Depends on cfb_pkg.
module cfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfb_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output cfb_pkg::job_t head
);

  cfb_pkg::job_t             mem_r [cfb_pkg::QDEPTH];
  logic [cfb_pkg::QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cfb_pkg::QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cfb_pkg::QCW-1:0]   count_r, count_nxt;

  always_comb begin
    full  = (count_r == cfb_pkg::QCW'(cfb_pkg::QDEPTH));
    valid = (count_r != '0);
    head  = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + cfb_pkg::QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + cfb_pkg::QPW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + cfb_pkg::QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cfb_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/cfb_back.sv]
// Back end: expands jobs into frame words in the output register, one per cycle unless stalled.
// Depends on cfb_pkg.
module cfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  cfb_pkg::job_t job,
  output logic          job_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output logic [15:0]   out_write_word,
  output logic          out_word_last
);

  cfb_pkg::st_t                st_r, st_nxt, st_cur;
  logic                        esc_r, esc_nxt;
  logic [cfb_pkg::HDR_IW-1:0]  idx_r, idx_nxt;
  logic                        ov_r, ov_nxt;
  logic [15:0]                 word_r, word_nxt;
  logic                        last_r, last_nxt;
  logic                        adv;
  logic                        byte_st;
  logic [7:0]                  cur_byte;
  logic                        byte_done;
  logic [15:0]                 word;
  logic                        fin;

  always_comb begin
    adv = job_valid && (!ov_r || out_pop);
    st_cur = st_r;
    if (st_r == cfb_pkg::ST_BEGIN) begin
      st_cur = job.first ? cfb_pkg::ST_STOP : cfb_pkg::ST_DATA;
    end

    byte_st  = 1'b0;
    cur_byte = job.data;
    unique case (st_cur)
      cfb_pkg::ST_HDR: begin
        byte_st  = 1'b1;
        cur_byte = cfb_pkg::HDR_BYTES[idx_r];
      end
      cfb_pkg::ST_DATA: begin
        byte_st  = 1'b1;
        cur_byte = job.data;
      end
      cfb_pkg::ST_CRCH: begin
        byte_st  = 1'b1;
        cur_byte = job.crc[15:8];
      end
      cfb_pkg::ST_CRCL: begin
        byte_st  = 1'b1;
        cur_byte = job.crc[7:0];
      end
      default: begin
        byte_st  = 1'b0;
        cur_byte = job.data;
      end
    endcase

    // escaped byte: send the escape word first, hold the state for the offset value
    byte_done = 1'b1;
    esc_nxt   = esc_r;
    word      = {8'h00, cur_byte};
    if (byte_st) begin
      if (!esc_r && cfb_pkg::needs_escape(cur_byte)) begin
        word      = {8'h00, cfb_pkg::ESC_BYTE};
        byte_done = 1'b0;
        esc_nxt   = 1'b1;
      end else begin
        word    = {8'h00, esc_r ? cur_byte - cfb_pkg::ESC_OFFSET : cur_byte};
        esc_nxt = 1'b0;
      end
    end

    fin     = 1'b0;
    st_nxt  = st_cur;
    idx_nxt = idx_r;
    unique case (st_cur)
      cfb_pkg::ST_STOP: begin
        word   = cfb_pkg::SPOOL_STOP;
        st_nxt = cfb_pkg::ST_START;
      end
      cfb_pkg::ST_START: begin
        word    = {8'h00, cfb_pkg::FLAG_START};
        st_nxt  = cfb_pkg::ST_HDR;
        idx_nxt = '0;
      end
      cfb_pkg::ST_HDR: begin
        if (byte_done) begin
          if (idx_r == cfb_pkg::HDR_IW'(cfb_pkg::HDR_LEN - 1)) begin
            st_nxt = cfb_pkg::ST_DATA;
          end else begin
            idx_nxt = idx_r + cfb_pkg::HDR_IW'(1);
          end
        end
      end
      cfb_pkg::ST_DATA: begin
        if (byte_done) begin
          if (job.last) begin
            st_nxt = cfb_pkg::ST_CRCH;
          end else begin
            st_nxt = cfb_pkg::ST_BEGIN;
            fin    = 1'b1;
          end
        end
      end
      cfb_pkg::ST_CRCH: begin
        if (byte_done) begin
          st_nxt = cfb_pkg::ST_CRCL;
        end
      end
      cfb_pkg::ST_CRCL: begin
        if (byte_done) begin
          st_nxt = cfb_pkg::ST_END;
        end
      end
      cfb_pkg::ST_END: begin
        word   = {8'h00, cfb_pkg::FLAG_END};
        st_nxt = cfb_pkg::ST_SPOOL;
      end
      cfb_pkg::ST_SPOOL: begin
        word   = cfb_pkg::SPOOL_START;
        st_nxt = cfb_pkg::ST_BEGIN;
        fin    = 1'b1;
      end
      default: begin
        st_nxt = cfb_pkg::ST_BEGIN;
      end
    endcase

    job_pop  = adv && fin;
    word_nxt = adv ? word : word_r;
    last_nxt = adv ? fin : last_r;
    ov_nxt   = adv ? 1'b1 : (out_pop ? 1'b0 : ov_r);

    out_empty      = !ov_r;
    out_write_word = word_r;
    out_word_last  = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= cfb_pkg::ST_BEGIN;
      esc_r <= 1'b0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (adv) begin
        st_r  <= st_nxt;
        esc_r <= esc_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

endmodule

[sv/command_frame_builder_crc_escape.sv]
// Command frame builder: payload bytes in, byte-stuffed CRC-16 framed words out.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
// Input channel: a byte with frame_first/frame_last is taken on a clock edge with
// in_push high and in_full low. Output channel: while out_empty is low the oldest
// word sits on out_write_word/out_word_last and leaves on an edge with out_pop high.
// out_word_last marks the final word produced for each input byte.
// The front end folds the byte into the CRC in its accept cycle and pushes a job into
// a four-entry queue; the sequencer emits one word per cycle from the queue head.
// A byte yields 1 to 15 words: one plain, two escaped, plus seven header words on a
// frame start and four to six trailer words on a frame end. Throughput is set by the
// sequencer at one word per cycle while the receiver keeps popping; with an empty queue
// the first word goes via the queue entry and then the output register to the outputs.
// When the receiver stalls, the output register holds its word, the sequencer waits,
// and the queue fills until in_full rises; nothing is dropped.
// Synchronous reset (rst_n low) empties the queue and output register and reseeds
// the CRC with 0x1D0F.
module command_frame_builder_crc_escape (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_frame_first,
  input  logic        in_frame_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_write_word,
  output logic        out_word_last
);

  cfb_pkg::job_t front_job;
  cfb_pkg::job_t head_job;
  logic          job_push;
  logic          job_pop;
  logic          q_full;
  logic          q_valid;

  assign in_full = q_full;

  cfb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .payload_byte (in_payload_byte),
    .frame_first  (in_frame_first),
    .frame_last   (in_frame_last),
    .q_full       (q_full),
    .job_push     (job_push),
    .job          (front_job)
  );

  cfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_job)
  );

  cfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job            (head_job),
    .job_pop        (job_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_write_word (out_write_word),
    .out_word_last  (out_word_last)
  );

`ifndef NO_ASSERTIONS
  // the start-spool word always closes a run
  a_spool_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_write_word == cfb_pkg::SPOOL_START) |-> out_word_last)
    else $error("start-spool word not marked last");

  // the stop-spool word always opens a run
  a_spool_stop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_write_word == cfb_pkg::SPOOL_STOP) |-> !out_word_last)
    else $error("stop-spool word marked last");

  // an accepted byte leaves a job in the queue
  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> q_valid)
    else $error("accepted byte did not reach the job queue");
`endif

endmodule

[test/command_frame_builder_crc_escape_tb.sv]
// Testbench for command_frame_builder_crc_escape: drives payload bytes and frames,
// predicts the stuffed, CRC-16 framed word stream and checks every popped word.
// Depends on cfb_pkg for the framing constants and on the RTL top level.
module command_frame_builder_crc_escape_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BYTES = 360;
  localparam int TAIL_START  = 300;
  localparam int CYCLE_LIMIT = 200000;

  class frame_word_scoreboard;
    typedef struct {
      logic [15:0] word;
      logic        last;
    } frame_word_t;

    frame_word_t pending_words[$];
    logic [15:0] crc_run;
    int          errors;

    function new();
      crc_run = cfb_pkg::CRC_SEED;
      errors  = 0;
    endfunction

    function logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        r = r[15] ? ((r << 1) ^ cfb_pkg::CRC_POLY) : (r << 1);
      end
      return r;
    endfunction

    function bit is_reserved(input logic [7:0] b);
      return b == cfb_pkg::FLAG_START || b == cfb_pkg::ESC_BYTE || b == cfb_pkg::FLAG_END;
    endfunction

    function void stuff(ref logic [15:0] run[$], input logic [7:0] b);
      if (is_reserved(b)) begin
        run.push_back({8'h00, cfb_pkg::ESC_BYTE});
        run.push_back({8'h00, b - cfb_pkg::ESC_OFFSET});
      end else begin
        run.push_back({8'h00, b});
      end
    endfunction

    // note one accepted input byte and queue the words it must produce
    function void note_byte(input logic [7:0] b, input logic first, input logic last);
      logic [15:0] run[$];
      frame_word_t fw;
      if (first) begin
        crc_run = cfb_pkg::CRC_SEED;
        run.push_back(cfb_pkg::SPOOL_STOP);
        run.push_back({8'h00, cfb_pkg::FLAG_START});
        for (int i = 0; i < cfb_pkg::HDR_LEN; i++) begin
          crc_run = crc_byte(crc_run, cfb_pkg::HDR_BYTES[i]);
          stuff(run, cfb_pkg::HDR_BYTES[i]);
        end
      end
      crc_run = crc_byte(crc_run, b);
      stuff(run, b);
      if (last) begin
        stuff(run, crc_run[15:8]);
        stuff(run, crc_run[7:0]);
        run.push_back({8'h00, cfb_pkg::FLAG_END});
        run.push_back(cfb_pkg::SPOOL_START);
        crc_run = cfb_pkg::CRC_SEED;
      end
      foreach (run[i]) begin
        fw.word = run[i];
        fw.last = (i == run.size() - 1);
        pending_words.push_back(fw);
      end
    endfunction

    function void check_word(input logic [15:0] word, input logic last);
      frame_word_t fw;
      if (pending_words.size() == 0) begin
        $error("unexpected word: write_word %h word_last %b", word, last);
        errors++;
        return;
      end
      fw = pending_words.pop_front();
      if (word !== fw.word) begin
        $error("write_word: expected %h, actual %h", fw.word, word);
        errors++;
      end
      if (last !== fw.last) begin
        $error("word_last: expected %b, actual %b", fw.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_payload_byte;
  logic        in_frame_first;
  logic        in_frame_last;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_write_word;
  logic        out_word_last;

  frame_word_scoreboard frame_sb = new();
  int bytes_sent = 0;
  bit quiet_tail = 1'b0;
  bit tx_gaps    = 1'b1;
  bit rx_started = 1'b0;

  command_frame_builder_crc_escape u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_payload_byte (in_payload_byte),
    .in_frame_first  (in_frame_first),
    .in_frame_last   (in_frame_last),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_write_word  (out_write_word),
    .out_word_last   (out_word_last)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return cfb_pkg::FLAG_START;
      1:       return cfb_pkg::ESC_BYTE;
      2:       return cfb_pkg::FLAG_END;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
    if (!quiet_tail && tx_gaps && $urandom_range(0, 2) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_payload_byte <= b;
    in_frame_first  <= first;
    in_frame_last   <= last;
    do @(posedge clk); while (in_full);
    frame_sb.note_byte(b, first, last);
    bytes_sent++;
  endtask

  // hold the sender until every expected word has been popped
  task automatic wait_drained();
    in_push <= 1'b0;
    while (frame_sb.outstanding() != 0) @(posedge clk);
  endtask

  // receiver: pop in bursts, with random stall stretches
  initial begin
    wait (rx_started);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 24)) begin
          @(posedge clk);
          if (!out_empty) frame_sb.check_word(out_write_word, out_word_last);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [15:0] hdr_crc;
    logic [15:0] c;
    logic [7:0]  hi_pick;
    logic [7:0]  lo_pick;
    int          len;
    int          next_drain;
    int          kind;

    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_payload_byte <= 8'h00;
    in_frame_first  <= 1'b0;
    in_frame_last   <= 1'b0;
    out_pop         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_started = 1'b1;

    // find one-byte frames whose CRC high or low byte needs stuffing
    hdr_crc = cfb_pkg::CRC_SEED;
    for (int i = 0; i < cfb_pkg::HDR_LEN; i++) begin
      hdr_crc = frame_sb.crc_byte(hdr_crc, cfb_pkg::HDR_BYTES[i]);
    end
    hi_pick = 8'h00;
    lo_pick = 8'h00;
    for (int b = 255; b >= 0; b--) begin
      c = frame_sb.crc_byte(hdr_crc, 8'(b));
      if (frame_sb.is_reserved(c[15:8])) hi_pick = 8'(b);
      if (frame_sb.is_reserved(c[7:0])) lo_pick = 8'(b);
    end

    // directed: byte with no frame start, then end without a start
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(cfb_pkg::FLAG_START, 1'b1, 1'b0);
    push_byte(cfb_pkg::ESC_BYTE, 1'b0, 1'b0);
    push_byte(cfb_pkg::FLAG_END, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(hi_pick, 1'b1, 1'b1);
    push_byte(lo_pick, 1'b1, 1'b1);
    // restart in the middle of a frame
    push_byte(8'h12, 1'b1, 1'b0);
    push_byte(8'h34, 1'b1, 1'b0);
    push_byte(8'h56, 1'b0, 1'b1);
    push_byte(8'h8D, 1'b1, 1'b1);
    push_byte(8'h9F, 1'b1, 1'b1);
    push_byte(8'hAA, 1'b1, 1'b0);
    push_byte(8'hAE, 1'b0, 1'b1);
    wait_drained();

    next_drain = 110;
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= TAIL_START) quiet_tail = 1'b1;
      tx_gaps = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        push_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (kind == 1) begin
        // broken frame: body with no start, end marker only sometimes
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          push_byte(pick_byte(), 1'b0, (j == len - 1) && ($urandom_range(0, 1) == 1));
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          push_byte(pick_byte(), j == 0, j == len - 1);
        end
      end
      if (bytes_sent >= next_drain) begin
        wait_drained();
        next_drain += 110;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (frame_sb.outstanding() != 0) begin
      $error("%0d expected words never arrived", frame_sb.outstanding());
      frame_sb.errors++;
    end
    if (frame_sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
